FILE: hw/rtl/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants for the frustum point/sphere cull core.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

	// Coordinate width (signed Q8.8 by default) and radius width
	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 16;
	localparam int MAT_W    = 64;
	localparam int ENTRY_W  = 16;

	// Default and maximum number of planes tested
	localparam int PLANE_COUNT_DEF = 6;
	localparam int PLANE_MAX       = 6;

	// Plane codes; NONE_FAILED marks an item that no plane rejects
	localparam logic [2:0] PLANE_LEFT   = 3'd0;
	localparam logic [2:0] PLANE_RIGHT  = 3'd1;
	localparam logic [2:0] PLANE_TOP    = 3'd2;
	localparam logic [2:0] PLANE_BOTTOM = 3'd3;
	localparam logic [2:0] PLANE_NEAR   = 3'd4;
	localparam logic [2:0] PLANE_FAR    = 3'd5;
	localparam logic [2:0] NONE_FAILED  = 3'd6;

	// Configuration register indexes
	localparam logic [1:0] REG_ROW_ONE   = 2'd0;
	localparam logic [1:0] REG_ROW_TWO   = 2'd1;
	localparam logic [1:0] REG_ROW_THREE = 2'd2;
	localparam logic [1:0] REG_ROW_FOUR  = 2'd3;

	// Input transaction payload
	typedef struct packed {
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic        [RADIUS_W-1:0] sphere_radius;
	} cull_in_t;

	// Result transaction payload
	typedef struct packed {
		logic       inside_res;
		logic [2:0] first_failed_plane;
	} cull_out_t;

	// Item travelling down the chain of plane cells
	typedef struct packed {
		logic [2:0] fail;
		cull_in_t   item;
	} cull_tok_t;

	// The four matrix rows, row one at index 0
	typedef logic [3:0][MAT_W-1:0] mat_rows_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpsc_cell.sv
// ----------------------------------------------------------------------------
// fpsc_cell
// One plane of the cull chain: two pipeline stages that build the plane from
// the matrix, form the dot product and record the first rejecting plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_cell #(
	parameter int PLANE_IDX = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire fpsc_pkg::mat_rows_t  mat,
	input  wire                       up_valid,
	input  wire fpsc_pkg::cull_tok_t  up_tok,
	output logic                      up_ready,
	output logic                      dn_valid,
	output fpsc_pkg::cull_tok_t       dn_tok,
	input  wire                       dn_ready
);
	import fpsc_pkg::*;

	localparam int COL    = PLANE_IDX / 2;
	localparam int N_W    = ENTRY_W + 1;
	localparam int PROD_W = N_W + COORD_W;
	localparam int RHS_W  = ENTRY_W + 3;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RSH_W  = RHS_W + 8;
	localparam int CMP_W  = (SUM_W > RSH_W) ? SUM_W : RSH_W;
	localparam logic [2:0] MY_CODE = 3'(PLANE_IDX);

	logic signed [N_W-1:0]    n_x, n_y, n_z;
	logic signed [N_W:0]      plane_d;
	logic signed [RHS_W-1:0]  rhs;
	logic signed [PROD_W-1:0] p_x, p_y, p_z;

	logic                     vld_s1, vld_s2;
	cull_tok_t                tok_s1, tok_s2;
	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [RHS_W-1:0]  rhs_s1;

	logic signed [CMP_W-1:0]  dot_sum, rhs_ext;
	logic                     rej;
	logic                     ready_s1, ready_s2;

	// Plane normal and distance from column four and this plane's column
	if (PLANE_IDX % 2 == 1) begin : g_plus
		assign n_x  = $signed({mat[0][63], mat[0][63:48]})
			+ $signed({mat[0][COL*16+15], mat[0][COL*16 +: 16]});
		assign n_y  = $signed({mat[1][63], mat[1][63:48]})
			+ $signed({mat[1][COL*16+15], mat[1][COL*16 +: 16]});
		assign n_z  = $signed({mat[2][63], mat[2][63:48]})
			+ $signed({mat[2][COL*16+15], mat[2][COL*16 +: 16]});
		assign plane_d = -($signed({{2{mat[3][63]}}, mat[3][63:48]})
			+ $signed({{2{mat[3][COL*16+15]}}, mat[3][COL*16 +: 16]}));
	end else begin : g_minus
		assign n_x  = $signed({mat[0][63], mat[0][63:48]})
			- $signed({mat[0][COL*16+15], mat[0][COL*16 +: 16]});
		assign n_y  = $signed({mat[1][63], mat[1][63:48]})
			- $signed({mat[1][COL*16+15], mat[1][COL*16 +: 16]});
		assign n_z  = $signed({mat[2][63], mat[2][63:48]})
			- $signed({mat[2][COL*16+15], mat[2][COL*16 +: 16]});
		assign plane_d = -($signed({{2{mat[3][63]}}, mat[3][63:48]})
			- $signed({{2{mat[3][COL*16+15]}}, mat[3][COL*16 +: 16]}));
	end

	// Stage one: products and radius-adjusted distance (Q8.8)
	always_comb begin
		p_x = PROD_W'(n_x) * PROD_W'(up_tok.item.pos_x);
		p_y = PROD_W'(n_y) * PROD_W'(up_tok.item.pos_y);
		p_z = PROD_W'(n_z) * PROD_W'(up_tok.item.pos_z);
		rhs = $signed({plane_d[N_W], plane_d})
			- $signed({{(RHS_W-RADIUS_W){1'b0}}, up_tok.item.sphere_radius});
	end

	// Stage two: sum of products against distance scaled to Q16.16
	always_comb begin
		dot_sum = $signed({{(CMP_W-PROD_W){px_s1[PROD_W-1]}}, px_s1})
			+ $signed({{(CMP_W-PROD_W){py_s1[PROD_W-1]}}, py_s1})
			+ $signed({{(CMP_W-PROD_W){pz_s1[PROD_W-1]}}, pz_s1});
		rhs_ext = $signed({{(CMP_W-RSH_W){rhs_s1[RHS_W-1]}}, rhs_s1, 8'h00});
		rej     = (dot_sum < rhs_ext);
	end

	// Stage handshake: a stage loads when empty or when it moves on
	assign ready_s2 = !vld_s2 || dn_ready;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ready_s1) vld_s1 <= up_valid;
			if (ready_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			tok_s1 <= up_tok;
			px_s1  <= p_x;
			py_s1  <= p_y;
			pz_s1  <= p_z;
			rhs_s1 <= rhs;
		end
		if (ready_s2 && vld_s1) begin
			tok_s2.item <= tok_s1.item;
			// keep an earlier rejection, else note this plane
			tok_s2.fail <= (tok_s1.fail == NONE_FAILED && rej) ? MY_CODE : tok_s1.fail;
		end
	end

	assign dn_valid = vld_s2;
	assign dn_tok   = tok_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/frustum_point_sphere_cull_core.sv
// ----------------------------------------------------------------------------
// frustum_point_sphere_cull_core
// Point and sphere test against the frustum planes of a view-projection
// matrix held in four configuration registers.
// ----------------------------------------------------------------------------
// One item is accepted per clock while item_stall is low. Each plane is a
// cell of two pipeline stages, multiply then sum-and-compare, and the cells
// form a chain in plane order so the first rejecting plane is the one
// recorded. Stages hold their item only while the result side stalls; empty
// stages keep filling, so input stall rises only when every stage is full.
// Matrix rows are written through the configuration port (ready always high)
// and must only change while the core is empty; an all-zero matrix passes
// every item.
`default_nettype none

module frustum_point_sphere_cull_core #(
	parameter int PLANE_COUNT = fpsc_pkg::PLANE_COUNT_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// item channel
	input  wire                        item_valid,
	output logic                       item_stall,
	input  wire fpsc_pkg::cull_in_t    item,
	// result channel
	output logic                       res_valid,
	input  wire                        res_stall,
	output fpsc_pkg::cull_out_t        res,
	// configuration write channel
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [1:0]                 cfg_index,
	input  wire  [fpsc_pkg::MAT_W-1:0] cfg_data
);
	import fpsc_pkg::*;

	mat_rows_t mat_q;
	logic      [PLANE_COUNT:0] vld_c;
	logic      [PLANE_COUNT:0] rdy_c;
	cull_tok_t tok_c [PLANE_COUNT+1];

	// Matrix registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_ONE:   mat_q[0] <= cfg_data;
				REG_ROW_TWO:   mat_q[1] <= cfg_data;
				REG_ROW_THREE: mat_q[2] <= cfg_data;
				REG_ROW_FOUR:  mat_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Head of the chain
	assign vld_c[0]      = item_valid;
	assign tok_c[0].fail = NONE_FAILED;
	assign tok_c[0].item = item;
	assign item_stall    = !rdy_c[0];

	// One cell per plane, in rejection order
	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		fpsc_cell #(
			.PLANE_IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.mat      (mat_q),
			.up_valid (vld_c[k]),
			.up_tok   (tok_c[k]),
			.up_ready (rdy_c[k]),
			.dn_valid (vld_c[k+1]),
			.dn_tok   (tok_c[k+1]),
			.dn_ready (rdy_c[k+1])
		);
	end

	// Result from the last cell's register
	assign rdy_c[PLANE_COUNT]     = !res_stall;
	assign res_valid              = vld_c[PLANE_COUNT];
	assign res.first_failed_plane = tok_c[PLANE_COUNT].fail;
	assign res.inside_res         = (tok_c[PLANE_COUNT].fail == NONE_FAILED);

endmodule

`default_nettype wire

FILE: hw/rtl/fpsc_checker.sv
// ----------------------------------------------------------------------------
// fpsc_checker
// Port-level checks for the frustum cull core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_checker #(
	parameter int PLANE_COUNT = fpsc_pkg::PLANE_COUNT_DEF
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        item_valid,
	input wire                        item_stall,
	input wire fpsc_pkg::cull_in_t    item,
	input wire                        res_valid,
	input wire                        res_stall,
	input wire fpsc_pkg::cull_out_t   res,
	input wire                        cfg_valid,
	input wire                        cfg_ready
);
	import fpsc_pkg::*;

	// A stalled item transaction holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("item changed while stalled");

	// A stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Visibility agrees with the failing plane code
	a_inside_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.inside_res == (res.first_failed_plane == NONE_FAILED)))
		else $error("inside flag disagrees with plane code");

	// Only tested planes may be reported
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.first_failed_plane == NONE_FAILED
			|| res.first_failed_plane < 3'(PLANE_COUNT)))
		else $error("failing plane out of range");

	// Configuration port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind frustum_point_sphere_cull_core fpsc_checker #(
	.PLANE_COUNT (PLANE_COUNT)
) u_fpsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.item       (item),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire
